// ----- hdl/torus_mesh_point_generator_unit_defines.svh -----
// assertion macros for the torus mesh point generator
// used by the top level, needs i_clk and i_rst_n in scope
`ifndef TORUS_MESH_POINT_GENERATOR_UNIT_DEFINES_SVH
`define TORUS_MESH_POINT_GENERATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define TMPG_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define TMPG_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define TMPG_ASSERT_IMPLIES(lbl, ante, cons)
`define TMPG_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- hdl/tmpg_pkg.sv -----
// shared types, constants and helper functions of the torus mesh point generator
// no dependencies
package tmpg_pkg;

    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int MAX_RINGS_DEF    = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    localparam int DIV_STEPS = 41;
    localparam int DIV_NUM_W = 41;
    localparam int DIV_Q_W   = 33;

    localparam logic [30:0] RST_OUTER  = 31'd65536;
    localparam logic [30:0] RST_INNER  = 31'd16384;
    localparam logic [16:0] RST_SWEEP  = 17'd65536;
    localparam logic [8:0]  RST_SEGCNT = 9'd16;
    localparam logic [8:0]  RST_RINGCNT = 9'd16;
    localparam logic [16:0] FULL_TURN_Q16 = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTER_RADIUS  = 3'd0,
        CFG_INNER_RADIUS  = 3'd1,
        CFG_SWEEP_ANGLE   = 3'd2,
        CFG_SEGMENT_COUNT = 3'd3,
        CFG_RING_COUNT    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [8:0] ring_index;
        logic [8:0] segment_index;
    } t_point_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [16:0] tri_a0;
        logic [16:0] tri_a1;
        logic [16:0] tri_a2;
        logic [16:0] tri_b0;
        logic [16:0] tri_b1;
        logic [16:0] tri_b2;
        logic        quad_valid;
    } t_point_out;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] num;
        logic [8:0]           rem;
        logic [DIV_Q_W-1:0]   q;
    } t_div_lane;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // one restoring long-division step, one quotient bit
    function automatic t_div_lane lane_step(input t_div_lane l, input logic [8:0] d);
        t_div_lane o;
        logic [9:0] trial;
        logic       ge;
        trial = {l.rem, l.num[DIV_NUM_W-1]};
        ge    = (trial >= {1'b0, d});
        o.num = l.num << 1;
        o.rem = ge ? 9'(trial - {1'b0, d}) : trial[8:0];
        o.q   = {l.q[DIV_Q_W-2:0], ge};
        return o;
    endfunction

    // q2.30 product back to q16.16, round half up, saturate
    function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] p);
        logic signed [65:0] t;
        logic signed [31:0] r;
        t = (p + 66'sd536870912) >>> 30;
        if (t > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (t < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = t[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/tmpg_cordic.sv -----
// pipelined rotation-mode cordic, cos and sin of a 32 bit turn fraction in q2.30
// depends on tmpg_pkg
module tmpg_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [31:0]        i_angle,
    output logic               o_valid,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);
    import tmpg_pkg::*;

    logic signed [33:0] r_x [0:CORDIC_STEPS];
    logic signed [33:0] r_y [0:CORDIC_STEPS];
    logic signed [32:0] r_z [0:CORDIC_STEPS];
    logic [1:0]         r_quad [0:CORDIC_STEPS];
    logic               r_v [0:CORDIC_STEPS];
    logic [31:0]        w_ua;
    logic signed [33:0] n_cos;
    logic signed [33:0] n_sin;
    logic signed [31:0] r_cos;
    logic signed [31:0] r_sin;
    logic               r_ov;

    assign w_ua = i_angle + 32'h20000000;

    always_ff @(posedge i_clk) begin
        r_x[0]    <= CORDIC_START;
        r_y[0]    <= '0;
        r_z[0]    <= $signed({3'b000, w_ua[29:0]}) - 33'sd536870912;
        r_quad[0] <= w_ua[31:30];
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        localparam logic signed [32:0] ATAN = {1'b0, atan_turn(i)};
        always_ff @(posedge i_clk) begin
            if (r_z[i] >= 0) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - ATAN;
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + ATAN;
            end
            r_quad[i+1] <= r_quad[i];
        end
    end

    always_comb begin
        case (r_quad[CORDIC_STEPS])
            2'd0: begin
                n_cos = r_x[CORDIC_STEPS];
                n_sin = r_y[CORDIC_STEPS];
            end
            2'd1: begin
                n_cos = -r_y[CORDIC_STEPS];
                n_sin = r_x[CORDIC_STEPS];
            end
            2'd2: begin
                n_cos = -r_x[CORDIC_STEPS];
                n_sin = -r_y[CORDIC_STEPS];
            end
            default: begin
                n_cos = r_y[CORDIC_STEPS];
                n_sin = -r_x[CORDIC_STEPS];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cos <= n_cos[31:0];
        r_sin <= n_sin[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CORDIC_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= CORDIC_STEPS; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_ov <= r_v[CORDIC_STEPS];
        end
    end

    assign o_valid = r_ov;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

// ----- hdl/torus_mesh_point_generator_unit.sv -----
// top level of the torus mesh point generator: config registers, divider pipeline,
// two cordic units, radius multipliers; depends on tmpg_pkg, tmpg_cordic and the defines header
//
// usage: drive i_point and pulse start; busy is always low, so one grid point can be
// given every cycle. each point yields exactly one result beat on o_result, marked by
// o_done for one cycle, after the divider, cordic and multiply stages. sustained rate is one
// point per cycle: a 41-step long-division pipeline turns indices into angles, a
// 26-stage cordic per angle gives sin and cos, and four multiply/round stages
// finish the position. registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data with no wait; write them only while no point is in flight.
// synchronous reset clears all valid bits and loads the default torus (radius 1.0,
// tube 0.25, full sweep, 16 by 16 grid). the receiver cannot stall: a result beat is
// presented once and must be taken in that cycle.
`include "torus_mesh_point_generator_unit_defines.svh"
module torus_mesh_point_generator_unit #(
    parameter int MAX_SEGMENTS = tmpg_pkg::MAX_SEGMENTS_DEF,
    parameter int MAX_RINGS    = tmpg_pkg::MAX_RINGS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_cfg_we,
    input  logic [tmpg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tmpg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  tmpg_pkg::t_point_in              i_point,
    output logic                             o_done,
    output tmpg_pkg::t_point_out             o_result
);
    import tmpg_pkg::*;

    localparam logic [8:0] SEG_LIM  = (MAX_SEGMENTS > 511) ? 9'd511 : 9'(MAX_SEGMENTS);
    localparam logic [8:0] RING_LIM = (MAX_RINGS > 511) ? 9'd511 : 9'(MAX_RINGS);

    typedef struct packed {
        t_div_lane  ring_l;
        t_div_lane  tube_l;
        t_div_lane  tv_l;
        logic [8:0] ring;
        logic [8:0] seg;
        logic       quad;
    } t_dstage;

    typedef struct packed {
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [8:0]  ring;
        logic [8:0]  seg;
        logic        quad;
    } t_carry;

    typedef struct packed {
        logic [16:0] a0;
        logic [16:0] a1;
        logic [16:0] a2;
        logic [16:0] b0;
        logic [16:0] b1;
        logic [16:0] b2;
    } t_tri;

    logic [30:0] r_outer;
    logic [30:0] r_inner;
    logic [16:0] r_sweep;
    logic [8:0]  r_segcnt;
    logic [8:0]  r_ringcnt;

    logic [8:0]  w_segs;
    logic [8:0]  w_rings;
    logic [16:0] w_sweep;

    t_dstage     r_ds [0:DIV_STEPS];
    logic        r_dv [0:DIV_STEPS];
    t_dstage     n_ds0;
    logic [8:0]  w_rc;
    logic [8:0]  w_sc;
    logic [25:0] w_rs;

    t_carry      r_dl [0:CORDIC_LAT-1];
    logic        w_tube_v;
    logic        w_ring_v;
    logic signed [31:0] w_ct;
    logic signed [31:0] w_st;
    logic signed [31:0] w_cp;
    logic signed [31:0] w_sp;

    logic               r_m1v;
    logic signed [63:0] r_m1_rt;
    logic signed [63:0] r_m1_z;
    logic signed [31:0] r_m1_cp;
    logic signed [31:0] r_m1_sp;
    t_carry             r_m1_c;
    t_tri               r_m1_tri;
    t_tri               n_tri;
    logic [9:0]         w_stride;
    logic [18:0]        w_cur;
    logic [19:0]        w_nxt;

    logic               r_m2v;
    logic signed [33:0] r_m2_rad;
    logic signed [31:0] r_m2_z;
    logic signed [31:0] r_m2_cp;
    logic signed [31:0] r_m2_sp;
    t_carry             r_m2_c;
    t_tri               r_m2_tri;
    logic signed [63:0] w_rt_rnd;

    logic               r_m3v;
    logic signed [65:0] r_m3_px;
    logic signed [65:0] r_m3_py;
    logic signed [31:0] r_m3_z;
    t_carry             r_m3_c;
    t_tri               r_m3_tri;

    logic               r_ov;
    t_point_out         r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer   <= RST_OUTER;
            r_inner   <= RST_INNER;
            r_sweep   <= RST_SWEEP;
            r_segcnt  <= RST_SEGCNT;
            r_ringcnt <= RST_RINGCNT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OUTER_RADIUS:  r_outer   <= i_cfg_data;
                CFG_INNER_RADIUS:  r_inner   <= i_cfg_data;
                CFG_SWEEP_ANGLE:   r_sweep   <= i_cfg_data[16:0];
                CFG_SEGMENT_COUNT: r_segcnt  <= i_cfg_data[8:0];
                CFG_RING_COUNT:    r_ringcnt <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign w_segs  = (r_segcnt == '0) ? 9'd1 : ((r_segcnt > SEG_LIM) ? SEG_LIM : r_segcnt);
    assign w_rings = (r_ringcnt == '0) ? 9'd1 : ((r_ringcnt > RING_LIM) ? RING_LIM : r_ringcnt);
    assign w_sweep = (r_sweep > FULL_TURN_Q16) ? FULL_TURN_Q16 : r_sweep;

    assign busy = 1'b0;

    // input stage: clamp, ring times sweep, load numerators
    always_comb begin
        w_rc = (i_point.ring_index > w_rings) ? w_rings : i_point.ring_index;
        w_sc = (i_point.segment_index > w_segs) ? w_segs : i_point.segment_index;
        w_rs = w_rc * w_sweep;
        n_ds0.ring_l.num = {w_rs[24:0], 16'd0};
        n_ds0.ring_l.rem = '0;
        n_ds0.ring_l.q   = '0;
        n_ds0.tube_l.num = {w_sc, 32'd0};
        n_ds0.tube_l.rem = '0;
        n_ds0.tube_l.q   = '0;
        n_ds0.tv_l.num   = {16'd0, w_rc, 16'd0};
        n_ds0.tv_l.rem   = '0;
        n_ds0.tv_l.q     = '0;
        n_ds0.ring       = w_rc;
        n_ds0.seg        = w_sc;
        n_ds0.quad       = (w_rc < w_rings) && (w_sc < w_segs);
    end

    always_ff @(posedge i_clk) begin
        r_ds[0] <= n_ds0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            r_ds[k+1].ring_l <= lane_step(r_ds[k].ring_l, w_rings);
            r_ds[k+1].tube_l <= lane_step(r_ds[k].tube_l, w_segs);
            r_ds[k+1].tv_l   <= lane_step(r_ds[k].tv_l, w_rings);
            r_ds[k+1].ring   <= r_ds[k].ring;
            r_ds[k+1].seg    <= r_ds[k].seg;
            r_ds[k+1].quad   <= r_ds[k].quad;
        end
    end

    tmpg_cordic u_tube (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_dv[DIV_STEPS]),
        .i_angle (r_ds[DIV_STEPS].tube_l.q[31:0]),
        .o_valid (w_tube_v),
        .o_cos   (w_ct),
        .o_sin   (w_st)
    );

    tmpg_cordic u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_dv[DIV_STEPS]),
        .i_angle (r_ds[DIV_STEPS].ring_l.q[31:0]),
        .o_valid (w_ring_v),
        .o_cos   (w_cp),
        .o_sin   (w_sp)
    );

    // side data riding alongside the cordic units
    always_ff @(posedge i_clk) begin
        r_dl[0].tex_u <= r_ds[DIV_STEPS].tube_l.q[32:16];
        r_dl[0].tex_v <= r_ds[DIV_STEPS].tv_l.q[16:0];
        r_dl[0].ring  <= r_ds[DIV_STEPS].ring;
        r_dl[0].seg   <= r_ds[DIV_STEPS].seg;
        r_dl[0].quad  <= r_ds[DIV_STEPS].quad;
        for (int j = 1; j < CORDIC_LAT; j++) begin
            r_dl[j] <= r_dl[j-1];
        end
    end

    // triangle indices
    always_comb begin
        w_stride = {1'b0, w_segs} + 10'd1;
        w_cur    = r_dl[CORDIC_LAT-1].ring * w_stride;
        w_nxt    = {1'b0, w_cur} + {10'd0, w_stride};
        if (r_dl[CORDIC_LAT-1].quad) begin
            n_tri.a0 = 17'(w_cur + {10'd0, r_dl[CORDIC_LAT-1].seg});
            n_tri.a1 = 17'(w_nxt + {11'd0, r_dl[CORDIC_LAT-1].seg});
            n_tri.a2 = 17'(w_cur + {10'd0, r_dl[CORDIC_LAT-1].seg} + 19'd1);
            n_tri.b0 = n_tri.a2;
            n_tri.b1 = n_tri.a1;
            n_tri.b2 = 17'(w_nxt + {11'd0, r_dl[CORDIC_LAT-1].seg} + 20'd1);
        end else begin
            n_tri = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1_rt  <= $signed({1'b0, r_inner}) * w_ct;
        r_m1_z   <= $signed({1'b0, r_inner}) * w_st;
        r_m1_cp  <= w_cp;
        r_m1_sp  <= w_sp;
        r_m1_c   <= r_dl[CORDIC_LAT-1];
        r_m1_tri <= n_tri;
    end

    assign w_rt_rnd = (r_m1_rt + 64'sd536870912) >>> 30;

    always_ff @(posedge i_clk) begin
        r_m2_rad <= $signed({3'b000, r_outer}) + w_rt_rnd[33:0];
        r_m2_z   <= rnd_sat({{2{r_m1_z[63]}}, r_m1_z});
        r_m2_cp  <= r_m1_cp;
        r_m2_sp  <= r_m1_sp;
        r_m2_c   <= r_m1_c;
        r_m2_tri <= r_m1_tri;
    end

    always_ff @(posedge i_clk) begin
        r_m3_px  <= r_m2_rad * r_m2_cp;
        r_m3_py  <= r_m2_rad * r_m2_sp;
        r_m3_z   <= r_m2_z;
        r_m3_c   <= r_m2_c;
        r_m3_tri <= r_m2_tri;
    end

    always_ff @(posedge i_clk) begin
        r_out.pos_x      <= rnd_sat(r_m3_px);
        r_out.pos_y      <= rnd_sat(r_m3_py);
        r_out.pos_z      <= r_m3_z;
        r_out.tex_u      <= r_m3_c.tex_u;
        r_out.tex_v      <= r_m3_c.tex_v;
        r_out.tri_a0     <= r_m3_tri.a0;
        r_out.tri_a1     <= r_m3_tri.a1;
        r_out.tri_a2     <= r_m3_tri.a2;
        r_out.tri_b0     <= r_m3_tri.b0;
        r_out.tri_b1     <= r_m3_tri.b1;
        r_out.tri_b2     <= r_m3_tri.b2;
        r_out.quad_valid <= r_m3_c.quad;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_m1v <= 1'b0;
            r_m2v <= 1'b0;
            r_m3v <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_dv[0] <= start && !busy;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_m1v <= w_tube_v;
            r_m2v <= r_m1v;
            r_m3v <= r_m2v;
            r_ov  <= r_m3v;
        end
    end

    assign o_done   = r_ov;
    assign o_result = r_out;

    `TMPG_ASSERT_IMPLIES(a_noquad_tri, o_done && !o_result.quad_valid, o_result.tri_a0 == '0 && o_result.tri_b2 == '0)
    `TMPG_ASSERT_IMPLIES(a_tex_range, o_done, o_result.tex_u <= 17'd65536 && o_result.tex_v <= 17'd65536)
    `TMPG_ASSERT_IMPLIES(a_quad_step, o_done && o_result.quad_valid, o_result.tri_a2 == 17'(o_result.tri_a0 + 17'd1))
    `TMPG_ASSERT_NEVER(a_cordic_align, w_tube_v != w_ring_v)

endmodule

// ----- bench/tmpg_checker.sv -----
// checker for the torus mesh point generator: predicts each result beat from the
// accepted grid points and the register writes it sees; depends on tmpg_pkg
`timescale 1ns / 100ps
module tmpg_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_busy,
    input  logic                                  i_cfg_we,
    input  logic [tmpg_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [tmpg_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  tmpg_pkg::t_point_in                   i_point,
    input  logic                                  i_done,
    input  tmpg_pkg::t_point_out                  i_result,
    output int                                    o_fail_count,
    output int                                    o_pending
);
    import tmpg_pkg::*;

    localparam longint GAIN_START = 64'sd652032874;

    logic [30:0] outer_r, inner_r;
    logic [16:0] sweep;
    logic [8:0]  seg_cnt, ring_cnt;
    t_point_out  vertex_q[$];

    longint arc_table[24] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
        'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};

    function automatic longint clamp_count(logic [8:0] c);
        if (c == 0) return 1;
        return (c > 256) ? 256 : longint'(c);
    endfunction

    function automatic void rotate(input logic [31:0] ang, output longint c,
                                   output longint s);
        logic [31:0] ua;
        longint x, y, z, dx, dy;
        ua = ang + 32'h20000000;
        z = longint'(ua[29:0]) - 64'sh20000000;
        x = GAIN_START;
        y = 0;
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arc_table[i];
            end else begin
                x += dx; y -= dy; z += arc_table[i];
            end
        end
        case (ua[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint scale_q30(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic t_point_out predict_vertex(t_point_in p);
        t_point_out o;
        longint segs, rings, sw, ring, seg, ct, st, cp, sp, rad, cur, nxt;
        logic [31:0] tube_ang, ring_ang;
        segs = clamp_count(seg_cnt);
        rings = clamp_count(ring_cnt);
        sw = (sweep > 65536) ? 65536 : longint'(sweep);
        ring = p.ring_index;
        seg = p.segment_index;
        if (ring > rings) ring = rings;
        if (seg > segs) seg = segs;
        tube_ang = 32'((seg <<< 32) / segs);
        ring_ang = 32'(((ring * sw) <<< 16) / rings);
        rotate(tube_ang, ct, st);
        rotate(ring_ang, cp, sp);
        rad = longint'(outer_r) + scale_q30(longint'(inner_r), ct);
        o = '0;
        o.pos_x = clip32(scale_q30(rad, cp));
        o.pos_y = clip32(scale_q30(rad, sp));
        o.pos_z = clip32(scale_q30(longint'(inner_r), st));
        o.tex_u = 17'((seg <<< 16) / segs);
        o.tex_v = 17'((ring <<< 16) / rings);
        if (ring < rings && seg < segs) begin
            cur = ring * (segs + 1);
            nxt = cur + segs + 1;
            o.tri_a0 = 17'(cur + seg);
            o.tri_a1 = 17'(nxt + seg);
            o.tri_a2 = 17'(cur + seg + 1);
            o.tri_b0 = 17'(cur + seg + 1);
            o.tri_b1 = 17'(nxt + seg);
            o.tri_b2 = 17'(nxt + seg + 1);
            o.quad_valid = 1'b1;
        end
        return o;
    endfunction

    task automatic cmp(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    assign o_pending = vertex_q.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_point_out e, a;
        if (!i_rst_n) begin
            outer_r <= RST_OUTER;
            inner_r <= RST_INNER;
            sweep <= RST_SWEEP;
            seg_cnt <= RST_SEGCNT;
            ring_cnt <= RST_RINGCNT;
            vertex_q.delete();
        end else begin
            if (i_done) begin
                if (vertex_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count++;
                end else begin
                    e = vertex_q.pop_front();
                    a = i_result;
                    cmp("pos_x", e.pos_x, a.pos_x);
                    cmp("pos_y", e.pos_y, a.pos_y);
                    cmp("pos_z", e.pos_z, a.pos_z);
                    cmp("tex_u", e.tex_u, a.tex_u);
                    cmp("tex_v", e.tex_v, a.tex_v);
                    cmp("tri_a0", e.tri_a0, a.tri_a0);
                    cmp("tri_a1", e.tri_a1, a.tri_a1);
                    cmp("tri_a2", e.tri_a2, a.tri_a2);
                    cmp("tri_b0", e.tri_b0, a.tri_b0);
                    cmp("tri_b1", e.tri_b1, a.tri_b1);
                    cmp("tri_b2", e.tri_b2, a.tri_b2);
                    cmp("quad_valid", e.quad_valid, a.quad_valid);
                end
            end
            if (i_start && !i_busy) vertex_q = {vertex_q, predict_vertex(i_point)};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OUTER_RADIUS:  outer_r <= i_cfg_data;
                    CFG_INNER_RADIUS:  inner_r <= i_cfg_data;
                    CFG_SWEEP_ANGLE:   sweep <= i_cfg_data[16:0];
                    CFG_SEGMENT_COUNT: seg_cnt <= i_cfg_data[8:0];
                    CFG_RING_COUNT:    ring_cnt <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ----- bench/testbench.sv -----
// top of the torus mesh point generator bench: clock, reset, config phases and
// grid point stimulus; depends on tmpg_pkg, tmpg_checker and the block
`timescale 1ns / 100ps
module testbench;
    import tmpg_pkg::*;

    localparam int DRAIN = 100;
    localparam longint LIMIT = 400000;

    logic i_clk = 0, i_rst_n = 0, start = 0, busy, i_cfg_we = 0, o_done;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    t_point_in i_point = '0;
    t_point_out o_result;
    int fails, pending, gap_pct;
    longint cycles = 0;

    always #5 i_clk = ~i_clk;

    torus_mesh_point_generator_unit dut (.*);

    tmpg_checker chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_cfg_we, .i_cfg_idx,
        .i_cfg_data, .i_point, .i_done(o_done), .i_result(o_result),
        .o_fail_count(fails), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_point(logic [8:0] ring, logic [8:0] seg);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_point <= '{ring_index: ring, segment_index: seg};
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [30:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
    endtask

    task automatic setup(logic [30:0] ro, logic [30:0] ri, logic [30:0] sw,
                         logic [30:0] sc, logic [30:0] rc);
        drain();
        write_reg(CFG_OUTER_RADIUS, ro);
        write_reg(CFG_INNER_RADIUS, ri);
        write_reg(CFG_SWEEP_ANGLE, sw);
        write_reg(CFG_SEGMENT_COUNT, sc);
        write_reg(CFG_RING_COUNT, rc);
        i_cfg_we <= 1'b0;
    endtask

    // mostly walks the grid in order, with some arbitrary points
    task automatic random_phase(int n);
        logic [8:0] r, s;
        r = 0;
        s = 0;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(3) == 0) begin
                r = 9'($urandom_range(511));
                s = 9'($urandom_range(511));
            end else begin
                s = s + 9'd1;
                if (s > 20) begin s = 0; r = r + 9'd1; end
                if (r > 20) r = 0;
            end
            send_point(r, s);
        end
    endtask

    initial begin
        gap_pct = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_point(0, 0);
        send_point(16, 16);
        send_point(511, 511);
        send_point(15, 15);
        send_point(3, 7);
        drain();
        write_reg(CFG_SEGMENT_COUNT, 0);
        i_cfg_we <= 1'b0;
        send_point(4, 9);
        setup(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h1FFFF, 31'h1FF, 0);
        send_point(0, 0);
        send_point(1, 0);
        send_point(0, 255);
        send_point(256, 256);
        send_point(300, 100);
        setup(0, 0, 1, 256, 256);
        send_point(255, 255);
        send_point(256, 0);
        send_point(128, 64);
        setup(65536, 16384, 0, 3, 3);
        send_point(2, 2);
        send_point(1, 1);
        send_point(9'h155, 9'h0AA);
        send_point(9'h0AA, 9'h155);
        drain();
        write_reg(t_cfg_idx'(3'd7), 31'h5A5A);
        i_cfg_we <= 1'b0;
        for (int ph = 0; ph < 12; ph++) begin
            gap_pct = (ph < 4) ? 19 : (ph < 8) ? 54 : 0;
            setup(31'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 21)),
                  31'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 19)),
                  31'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 65536)),
                  31'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(1, 24)),
                  31'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(1, 24)));
            random_phase(145);
        end
        drain();
        if (fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ----- torus_mesh_point_generator_unit.f -----
+incdir+hdl
hdl/tmpg_pkg.sv
hdl/tmpg_cordic.sv
hdl/torus_mesh_point_generator_unit.sv
bench/tmpg_checker.sv
bench/testbench.sv
